### design/rc4_pkg.sv
// shared types and constants for the rc4 stream cipher
`default_nettype none

package rc4_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SBOX_DEPTH  = 256;
  localparam int unsigned KEY_LEN_W   = 9;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RST = 9'd16;

  // request opcodes carried in the mode field
  typedef enum logic [1:0] {
    MODE_KEY   = 2'd0,
    MODE_KSA   = 2'd1,
    MODE_CRYPT = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_e;

  // one access request to the s-box memory
  typedef struct packed {
    logic              clr;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_addr;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
  } sbox_req_t;

endpackage

`default_nettype wire

### design/rc4_sbox_mem.sv
// s-box memory with per-entry valid bits; an unwritten entry reads as its own index
`default_nettype none

module rc4_sbox_mem
  import rc4_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sbox_req_t         req_i,
  output logic [BYTE_W-1:0]      rdata_o
);

  logic [BYTE_W-1:0]     mem_q [SBOX_DEPTH];
  logic [SBOX_DEPTH-1:0] vld_q;
  logic [BYTE_W-1:0]     rd_data_q;
  logic [BYTE_W-1:0]     rd_addr_q;
  logic                  rd_vld_q;

  // storage array and read data register
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
      rd_addr_q <= req_i.rd_addr;
    end
  end

  // valid bits, cleared as a whole to restore the identity permutation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.rd_addr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_data_q : rd_addr_q;

endmodule

`default_nettype wire

### design/rc4_key_mem.sv
// key store: one write port, one registered read port
`default_nettype none

module rc4_key_mem
  import rc4_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [BYTE_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic [BYTE_W-1:0]      rdata_o
);

  logic [BYTE_W-1:0] mem_q [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### design/rc4_ctrl.sv
// sequencer with the shared byte adder for key schedule and keystream steps
`default_nettype none

module rc4_ctrl
  import rc4_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = 256,
  parameter int unsigned KEY_AW        = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [KEY_LEN_W-1:0] cfg_wdata_i,
  // request channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           mode_i,
  input  wire logic [BYTE_W-1:0]    key_index_i,
  input  wire logic [BYTE_W-1:0]    key_byte_i,
  input  wire logic [BYTE_W-1:0]    text_byte_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [BYTE_W-1:0]         out_byte_o,
  // s-box memory
  output sbox_req_t                 sbox_req_o,
  input  wire logic [BYTE_W-1:0]    sbox_rdata_i,
  // key store
  output logic                      key_we_o,
  output logic [KEY_AW-1:0]         key_waddr_o,
  output logic [BYTE_W-1:0]         key_wdata_o,
  output logic                      key_re_o,
  output logic [KEY_AW-1:0]         key_raddr_o,
  input  wire logic [BYTE_W-1:0]    key_rdata_i
);

  localparam logic [KEY_LEN_W-1:0] MaxLen = KEY_LEN_W'(MAX_KEY_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K_RD,
    ST_K_ADD,
    ST_K_WJ,
    ST_K_WK,
    ST_C_RI,
    ST_C_RJ,
    ST_C_WI,
    ST_C_WJ,
    ST_C_RT,
    ST_C_OUT
  } state_e;

  state_e                state_q, state_d;
  logic [KEY_LEN_W-1:0]  key_len_q, key_len_d;
  logic [KEY_LEN_W-1:0]  len_q, len_d;
  logic [BYTE_W-1:0]     i_q, i_d;
  logic [BYTE_W-1:0]     j_q, j_d;
  logic [BYTE_W-1:0]     k_q, k_d;
  logic [KEY_AW-1:0]     kidx_q, kidx_d;
  logic [BYTE_W-1:0]     si_q, si_d;
  logic [BYTE_W-1:0]     sj_q, sj_d;
  logic [BYTE_W-1:0]     text_q, text_d;
  logic                  out_vld_q, out_vld_d;
  logic [BYTE_W-1:0]     out_byte_q, out_byte_d;

  logic                  accept;
  mode_e                 mode;
  logic [KEY_LEN_W-1:0]  eff_len;
  logic                  kidx_wrap;
  logic                  key_in_range;
  logic [BYTE_W-1:0]     add_a, add_b, add_c, add_sum;
  logic                  out_free;

  assign accept       = in_valid_i && (state_q == ST_IDLE);
  assign mode         = mode_e'(mode_i);
  assign key_in_range = ({1'b0, key_index_i} < MaxLen);
  assign kidx_wrap    = (KEY_LEN_W'(kidx_q) == (len_q - KEY_LEN_W'(1)));
  assign out_free     = !out_vld_q || !out_stall_i;

  // key length clamped into the legal range
  always_comb begin
    eff_len = key_len_q;
    if (key_len_q == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_len_q > MaxLen) begin
      eff_len = MaxLen;
    end
  end

  // shared byte adder: j update in both phases, keystream index in crypt
  always_comb begin
    add_a = j_q;
    add_b = sbox_rdata_i;
    add_c = '0;
    case (state_q)
      ST_K_ADD: add_c = key_rdata_i;
      ST_C_RT: begin
        add_a = si_q;
        add_b = sj_q;
      end
      default: ;
    endcase
  end
  assign add_sum = add_a + add_b + add_c;

  // sequencer next state and memory requests
  always_comb begin
    state_d    = state_q;
    key_len_d  = key_len_q;
    len_d      = len_q;
    i_d        = i_q;
    j_d        = j_q;
    k_d        = k_q;
    kidx_d     = kidx_q;
    si_d       = si_q;
    sj_d       = sj_q;
    text_d     = text_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_byte_d = out_byte_q;

    sbox_req_o  = '0;
    key_we_o    = 1'b0;
    key_waddr_o = key_index_i[KEY_AW-1:0];
    key_wdata_o = key_byte_i;
    key_re_o    = 1'b0;
    key_raddr_o = kidx_q;

    if (cfg_we_i) begin
      key_len_d = cfg_wdata_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode)
            MODE_KEY: key_we_o = key_in_range;
            MODE_KSA: begin
              sbox_req_o.clr = 1'b1;
              len_d          = eff_len;
              k_d            = '0;
              kidx_d         = '0;
              i_d            = '0;
              j_d            = '0;
              state_d        = ST_K_RD;
            end
            MODE_CRYPT: begin
              text_d  = text_byte_i;
              i_d     = i_q + BYTE_W'(1);
              state_d = ST_C_RI;
            end
            default: ;
          endcase
        end
      end
      // key schedule: read s[k] and key byte
      ST_K_RD: begin
        sbox_req_o.rd_en   = 1'b1;
        sbox_req_o.rd_addr = k_q;
        key_re_o           = 1'b1;
        state_d            = ST_K_ADD;
      end
      // j += s[k] + key, then read s[j]
      ST_K_ADD: begin
        si_d               = sbox_rdata_i;
        j_d                = add_sum;
        sbox_req_o.rd_en   = 1'b1;
        sbox_req_o.rd_addr = add_sum;
        state_d            = ST_K_WJ;
      end
      ST_K_WJ: begin
        sj_d               = sbox_rdata_i;
        sbox_req_o.wr_en   = 1'b1;
        sbox_req_o.wr_addr = j_q;
        sbox_req_o.wr_data = si_q;
        state_d            = ST_K_WK;
      end
      ST_K_WK: begin
        sbox_req_o.wr_en   = 1'b1;
        sbox_req_o.wr_addr = k_q;
        sbox_req_o.wr_data = sj_q;
        k_d                = k_q + BYTE_W'(1);
        kidx_d             = kidx_wrap ? '0 : kidx_q + KEY_AW'(1);
        if (k_q == BYTE_W'(SBOX_DEPTH - 1)) begin
          j_d     = '0;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_K_RD;
        end
      end
      // crypt: read s[i]
      ST_C_RI: begin
        sbox_req_o.rd_en   = 1'b1;
        sbox_req_o.rd_addr = i_q;
        state_d            = ST_C_RJ;
      end
      ST_C_RJ: begin
        si_d               = sbox_rdata_i;
        j_d                = add_sum;
        sbox_req_o.rd_en   = 1'b1;
        sbox_req_o.rd_addr = add_sum;
        state_d            = ST_C_WI;
      end
      ST_C_WI: begin
        sj_d               = sbox_rdata_i;
        sbox_req_o.wr_en   = 1'b1;
        sbox_req_o.wr_addr = i_q;
        sbox_req_o.wr_data = sbox_rdata_i;
        state_d            = ST_C_WJ;
      end
      ST_C_WJ: begin
        sbox_req_o.wr_en   = 1'b1;
        sbox_req_o.wr_addr = j_q;
        sbox_req_o.wr_data = si_q;
        state_d            = ST_C_RT;
      end
      // keystream byte at s[s[i] + s[j]]
      ST_C_RT: begin
        sbox_req_o.rd_en   = 1'b1;
        sbox_req_o.rd_addr = add_sum;
        state_d            = ST_C_OUT;
      end
      ST_C_OUT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_byte_d = text_q ^ sbox_rdata_i;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      key_len_q  <= KEY_LEN_RST;
      len_q      <= KEY_LEN_W'(1);
      i_q        <= '0;
      j_q        <= '0;
      k_q        <= '0;
      kidx_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      key_len_q  <= key_len_d;
      len_q      <= len_d;
      i_q        <= i_d;
      j_q        <= j_d;
      k_q        <= k_d;
      kidx_q     <= kidx_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    sj_q       <= sj_d;
    text_q     <= text_d;
    out_byte_q <= out_byte_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_byte_o  = out_byte_q;

endmodule

`default_nettype wire

### design/rc4_stream_cipher.sv
// rc4 stream cipher top level
//
// request channel: in_valid_i / in_stall_o with mode_i, key_index_i,
// key_byte_i and text_byte_i. mode 0 writes key_byte_i into the key store at
// key_index_i, mode 1 runs the key schedule, mode 2 xors text_byte_i with the
// next keystream byte, mode 3 is dropped.
// result channel: out_valid_o / out_stall_i with out_byte_o, one result per
// mode 2 request only.
// key_length is written through cfg_we_i / cfg_wdata_i; the user must do so only
// while idle, the block does not enforce it. a key write leaves the block idle; a
// crypt request reads s[i] and s[j], writes them swapped and reads the keystream
// byte; the key schedule clears the s-box, then reads, adds and writes s[j] and
// s[k] for all 256 entries; no request is taken until a sequence ends. all steps
// go through one s-box memory port pair and one byte adder, one access per cycle.
// reset: i and j clear, key_length returns to 16, the s-box reads as the identity
// permutation; the key store is undefined until written. a stalled result stays
// in the output register; crypt waits in its last step until that register is free.
`default_nettype none

module rc4_stream_cipher
  import rc4_pkg::*;
#(
  parameter int unsigned MAX_KEY_BYTES = 256
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [KEY_LEN_W-1:0] cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           mode_i,
  input  wire logic [BYTE_W-1:0]    key_index_i,
  input  wire logic [BYTE_W-1:0]    key_byte_i,
  input  wire logic [BYTE_W-1:0]    text_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [BYTE_W-1:0]         out_byte_o
);

  localparam int unsigned KeyAw = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  sbox_req_t          sbox_req;
  logic [BYTE_W-1:0]  sbox_rdata;
  logic               key_we;
  logic [KeyAw-1:0]   key_waddr;
  logic [BYTE_W-1:0]  key_wdata;
  logic               key_re;
  logic [KeyAw-1:0]   key_raddr;
  logic [BYTE_W-1:0]  key_rdata;

  // sequencer
  rc4_ctrl #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES),
    .KEY_AW       (KeyAw)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .key_index_i (key_index_i),
    .key_byte_i  (key_byte_i),
    .text_byte_i (text_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .sbox_req_o  (sbox_req),
    .sbox_rdata_i(sbox_rdata),
    .key_we_o    (key_we),
    .key_waddr_o (key_waddr),
    .key_wdata_o (key_wdata),
    .key_re_o    (key_re),
    .key_raddr_o (key_raddr),
    .key_rdata_i (key_rdata)
  );

  // permutation state
  rc4_sbox_mem u_sbox (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sbox_req),
    .rdata_o(sbox_rdata)
  );

  // key bytes
  rc4_key_mem #(
    .DEPTH(MAX_KEY_BYTES),
    .AW   (KeyAw)
  ) u_key (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_waddr),
    .wdata_i(key_wdata),
    .re_i   (key_re),
    .raddr_i(key_raddr),
    .rdata_o(key_rdata)
  );

endmodule

`default_nettype wire

### design/rc4_checker.sv
// port-level checks for the rc4 stream cipher, bound to the top level
`default_nettype none

module rc4_checker
  import rc4_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic [1:0]        mode_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [BYTE_W-1:0] out_byte_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o))
    else $error("stalled result changed");

  // a crypt request occupies the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == MODE_CRYPT) |=> in_stall_o)
    else $error("crypt request did not occupy the block");

  // a key write completes in its own cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (mode_i == MODE_KEY) |=> !in_stall_o)
    else $error("key write left the block busy");

  // a new result only comes out of a busy sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in flight");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .mode_i     (mode_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_byte_o (out_byte_o)
);

`default_nettype wire
